// File: rtl/stepper_move_dispatch_can_framer_unit_macros.svh
// Assertion macros shared by the dispatcher checks.
`ifndef STEPPER_MOVE_DISPATCH_CAN_FRAMER_UNIT_MACROS_SVH
`define STEPPER_MOVE_DISPATCH_CAN_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SMDC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SMDC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/smdc_pkg.sv
// Types and constants of the stepper move dispatcher and CAN framer.
package smdc_pkg;

    localparam logic [7:0] FUNC_BYTE = 8'hFD;
    localparam logic [7:0] TERM_BYTE = 8'h6B;
    localparam int         CMD_LEN   = 13;

    // Command body after address and function byte, split 7 + rest.
    localparam int         FRAME0_TAKE = 7;
    localparam logic [3:0] DLC_FRAME0  = 4'(FRAME0_TAKE + 1);
    localparam logic [3:0] DLC_FRAME1  = 4'(CMD_LEN - 2 - FRAME0_TAKE + 1);

    localparam logic [7:0] ADDR_CH0 = 8'd1;
    localparam logic [7:0] ADDR_CH1 = 8'd2;
    localparam logic [7:0] ADDR_CH2 = 8'd3;
    localparam logic [7:0] ADDR_CH3 = 8'd6;

    localparam int CMD_DEPTH_DEF = 2;
    localparam int OUT_DEPTH     = 2;

    typedef struct packed {
        logic [7:0]  motor_addr;
        logic [7:0]  move_dir;
        logic [15:0] speed;
        logic [7:0]  accel;
        logic [31:0] position;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [1:0]  channel;
        logic        step_dir;
        logic [31:0] pulse_count;
        logic [15:0] can_ext_id;
        logic [3:0]  can_dlc;
        logic [63:0] can_data;
        logic        last;
    } t_result;

    // Classified command handed from front to back.
    typedef struct packed {
        logic       is_can;
        logic [1:0] channel;
        t_item      item;
    } t_cmd;

endpackage

// File: rtl/smdc_fifo.sv
// Small register queue with a combinational head read.
module smdc_fifo import smdc_pkg::*; #(
    parameter int DEPTH = CMD_DEPTH_DEF,
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/smdc_front.sv
// Front end: classify move commands by address and queue them for the back end.
module smdc_front import smdc_pkg::*; #(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_cmd_valid,
    output t_cmd  o_cmd,
    input  logic  i_cmd_pop
);
    t_cmd             cmd_in;
    logic [$bits(t_cmd)-1:0] cmd_bits;

    always_comb begin
        cmd_in         = '0;
        cmd_in.item    = i_item;
        cmd_in.is_can  = 1'b0;
        unique case (i_item.motor_addr)
            ADDR_CH0: cmd_in.channel = 2'd0;
            ADDR_CH1: cmd_in.channel = 2'd1;
            ADDR_CH2: cmd_in.channel = 2'd2;
            ADDR_CH3: cmd_in.channel = 2'd3;
            default:  cmd_in.is_can  = 1'b1;
        endcase
    end

    smdc_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .o_valid (o_cmd_valid),
        .o_data  (cmd_bits),
        .i_pop   (i_cmd_pop)
    );

    assign o_cmd = t_cmd'(cmd_bits);

endmodule

// File: rtl/smdc_back.sv
// Back end: run step commands against stored positions, frame CAN commands.
module smdc_back import smdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_empty,
    output t_result o_result,
    input  logic    i_pop
);
    logic [31:0] r_prev [4];
    logic        r_frame;

    logic        out_full;
    logic        res_valid;
    logic        fire;
    logic [31:0] old_pos, new_pos;
    logic        pos_gt;
    logic [31:0] diff_up, diff_dn;
    t_result     res;
    logic [$bits(t_result)-1:0] res_bits;

    assign fire      = i_cmd_valid && !out_full;
    assign o_cmd_pop = fire && (!i_cmd.is_can || r_frame);

    // Both differences in parallel; the compare picks the nonnegative one.
    assign new_pos = i_cmd.item.position;
    assign old_pos = r_prev[i_cmd.channel];
    assign pos_gt  = new_pos > old_pos;
    assign diff_up = new_pos - old_pos;
    assign diff_dn = old_pos - new_pos;

    always_comb begin
        res = '0;
        if (!i_cmd.is_can) begin
            res.kind        = 1'b0;
            res.channel     = i_cmd.channel;
            res.step_dir    = pos_gt;
            res.pulse_count = pos_gt ? diff_up : diff_dn;
            res.last        = 1'b1;
        end else begin
            res.kind       = 1'b1;
            res.can_ext_id = {i_cmd.item.motor_addr, 7'd0, r_frame};
            res.last       = r_frame;
            if (!r_frame) begin
                res.can_dlc  = DLC_FRAME0;
                res.can_data = {i_cmd.item.position[15:8],
                                i_cmd.item.position[23:16],
                                i_cmd.item.position[31:24],
                                i_cmd.item.accel,
                                i_cmd.item.speed[7:0],
                                i_cmd.item.speed[15:8],
                                i_cmd.item.move_dir,
                                FUNC_BYTE};
            end else begin
                res.can_dlc  = DLC_FRAME1;
                res.can_data = {24'd0, TERM_BYTE, 16'd0,
                                i_cmd.item.position[7:0], FUNC_BYTE};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_prev[i] <= '0;
            end
        end else if (fire) begin
            if (i_cmd.is_can) begin
                r_frame <= !r_frame;
            end else begin
                r_prev[i_cmd.channel] <= new_pos;
            end
        end
    end

    smdc_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_result))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_full  (out_full),
        .o_valid (res_valid),
        .o_data  (res_bits),
        .i_pop   (i_pop)
    );

    assign o_empty  = !res_valid;
    assign o_result = t_result'(res_bits);

endmodule

// File: rtl/stepper_move_dispatch_can_framer_unit.sv
// Top level of the stepper move dispatcher and CAN framer.
//
// Input queue: drive i_item and raise push; a beat is taken at a clock edge
// with push high and full low. Result queue: while empty is low the oldest
// result sits on o_result; raise pop to take it.
// Addresses 1, 2, 3 and 6 are local step channels 0..3: one result with
// direction and pulse count against the last stored position of that channel,
// which is then replaced. Any other address yields two CAN frames (frame 0 with
// dlc 8, frame 1 with dlc 5, last set on frame 1); stored positions are kept.
// A result passes through the registered command queue and then the output
// queue before it is on o_result; frame 1 is emitted after frame 0.
// While its two-beat output queue has room, the back end emits one result per
// cycle, for one local command or one CAN frame; a CAN command needs both.
// A short command queue sits between front and back, so the front keeps taking
// beats while the back or the receiver stalls, until that queue fills.
// When pop stays low the output queue fills, the back end holds, and then
// full rises. Reset empties both queues and clears all stored positions to 0.
`include "stepper_move_dispatch_can_framer_unit_macros.svh"
module stepper_move_dispatch_can_framer_unit import smdc_pkg::*; #(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    input  t_item   i_item,
    output logic    full,
    output logic    empty,
    output t_result o_result,
    input  logic    pop
);
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    smdc_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    smdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .o_result    (o_result),
        .i_pop       (pop)
    );

    `SMDC_ASSERT_NOW(a_local_single, !empty && !o_result.kind, o_result.last, "local result not last")
    `SMDC_ASSERT_NEXT(a_frame1_follows, pop && !empty && !o_result.last, !empty && o_result.kind && o_result.last, "frame 1 does not follow frame 0")
    `SMDC_ASSERT_NOW(a_can_cmd_pop, cmd_pop && cmd.is_can, !empty || cmd_valid, "CAN command retired without frames")

endmodule
